/* hw/rtl/rprc_pkg.sv */
// Shared types, codes and constants for the recorder power and record controller.
`default_nettype none

package rprc_pkg;

    localparam int unsigned TIME_W = 32;
    localparam int unsigned CODE_W = 8;
    localparam int unsigned CMD_W = 4;
    localparam int unsigned ADDR_W = 3;
    localparam int unsigned DATA_W = 32;

    localparam logic [TIME_W-1:0] BOOT_TIMEOUT_RESET = 32'd10000;
    localparam logic [0:0] REG_BOOT_TIMEOUT = 1'b0;

    localparam logic [CODE_W-1:0] ERR_CLEAR = 8'd0;
    localparam logic [CODE_W-1:0] ERR_BAT_CRIT = 8'd1;
    localparam logic [CODE_W-1:0] ERR_LOCK = 8'd2;
    localparam logic [CODE_W-1:0] ERR_BOOT_TIMEOUT = 8'd3;
    localparam logic [CODE_W-1:0] BAT_UNSET = 8'd0;
    localparam logic [CODE_W-1:0] BAT_CRIT = 8'd1;

    localparam logic [CMD_W-1:0] CMD_TICK = 4'd0;
    localparam logic [CMD_W-1:0] CMD_START = 4'd1;
    localparam logic [CMD_W-1:0] CMD_BATTERY = 4'd2;
    localparam logic [CMD_W-1:0] CMD_LOCK_ENTER = 4'd3;
    localparam logic [CMD_W-1:0] CMD_LOCK_EXIT = 4'd4;
    localparam logic [CMD_W-1:0] CMD_READY = 4'd5;
    localparam logic [CMD_W-1:0] CMD_OFF = 4'd6;
    localparam logic [CMD_W-1:0] CMD_REC_START = 4'd7;
    localparam logic [CMD_W-1:0] CMD_REC_STOP = 4'd8;
    localparam logic [CMD_W-1:0] CMD_ERROR = 4'd9;
    localparam logic [CMD_W-1:0] CMD_SHORT = 4'd10;
    localparam logic [CMD_W-1:0] CMD_LONG = 4'd11;

    typedef enum logic [2:0] {
        MODE_OFF       = 3'd0,
        MODE_BOOTING   = 3'd1,
        MODE_IDLE      = 3'd2,
        MODE_RECORDING = 3'd3,
        MODE_LOW_BAT   = 3'd4,
        MODE_ERROR     = 3'd5,
        MODE_LOCKOUT   = 3'd6
    } mode_t;

    typedef enum logic [1:0] {
        ACT_NONE  = 2'd0,
        ACT_SHORT = 2'd1,
        ACT_LONG  = 2'd2
    } press_t;

    typedef struct packed {
        mode_t              mode;
        logic [CODE_W-1:0]  battery_code;
        logic               locked;
        logic [CODE_W-1:0]  error_code;
        logic [TIME_W-1:0]  boot_deadline;
        logic               shutdown_wait;
        logic               stop_wait;
    } ctrl_state_t;

    typedef struct packed {
        press_t             action;
        mode_t              mode;
        logic [CODE_W-1:0]  error_code;
        logic [CODE_W-1:0]  battery_code;
        logic               locked;
        logic               shutdown_wait;
        logic               cue_state_enter;
        logic               cue_error;
        logic               cue_confirm;
        logic               cue_stop;
    } result_t;

endpackage

`default_nettype wire

/* hw/rtl/rprc_step.sv */
// Next-state and result logic for one event word of the controller.
`default_nettype none

module rprc_step
    import rprc_pkg::*;
(
    input  wire ctrl_state_t        cur,
    input  wire logic [CMD_W-1:0]   command,
    input  wire logic [CODE_W-1:0]  arg,
    input  wire logic [TIME_W-1:0]  now_ms,
    input  wire logic [TIME_W-1:0]  boot_timeout_ms,
    output ctrl_state_t             nxt,
    output result_t                 res
);

    logic [TIME_W-1:0] since_deadline;
    logic              enter;
    logic              err;
    logic              confirm;
    logic              stop_cue;
    press_t            act;

    assign since_deadline = now_ms - cur.boot_deadline;

    always_comb
    begin
        nxt = cur;
        enter = 1'b0;
        err = 1'b0;
        confirm = 1'b0;
        stop_cue = 1'b0;
        act = ACT_NONE;

        if (command == CMD_START)
        begin
            nxt.mode = MODE_BOOTING;
            nxt.battery_code = BAT_UNSET;
            nxt.locked = 1'b0;
            nxt.error_code = ERR_CLEAR;
            nxt.shutdown_wait = 1'b0;
            nxt.stop_wait = 1'b0;
            nxt.boot_deadline = now_ms + boot_timeout_ms;
            enter = 1'b1;
            act = ACT_LONG;
        end
        else
        begin
            // The deadline has passed once the wrapped difference is not negative.
            if (cur.mode == MODE_BOOTING && !since_deadline[TIME_W-1] && !cur.locked)
            begin
                nxt.error_code = ERR_BOOT_TIMEOUT;
                nxt.mode = MODE_ERROR;
                err = 1'b1;
                enter = 1'b1;
            end

            unique case (command)
                CMD_BATTERY:
                begin
                    nxt.battery_code = arg;
                    if (!nxt.locked && arg == BAT_CRIT)
                    begin
                        nxt.error_code = ERR_BAT_CRIT;
                        if (nxt.mode != MODE_LOW_BAT)
                        begin
                            nxt.mode = MODE_LOW_BAT;
                            enter = 1'b1;
                        end
                    end
                end
                CMD_LOCK_ENTER:
                begin
                    nxt.locked = 1'b1;
                    nxt.error_code = ERR_LOCK;
                    if (nxt.mode != MODE_LOCKOUT)
                    begin
                        nxt.mode = MODE_LOCKOUT;
                        enter = 1'b1;
                    end
                end
                CMD_LOCK_EXIT:
                begin
                    nxt.locked = 1'b0;
                    nxt.error_code = ERR_CLEAR;
                    if (nxt.mode != MODE_OFF)
                    begin
                        nxt.mode = MODE_OFF;
                        enter = 1'b1;
                    end
                end
                CMD_READY:
                begin
                    if (nxt.mode == MODE_BOOTING && !nxt.locked)
                    begin
                        nxt.error_code = ERR_CLEAR;
                        nxt.mode = MODE_IDLE;
                        enter = 1'b1;
                        confirm = 1'b1;
                    end
                end
                CMD_OFF:
                begin
                    if (!nxt.locked)
                    begin
                        nxt.shutdown_wait = 1'b0;
                        nxt.stop_wait = 1'b0;
                        nxt.error_code = ERR_CLEAR;
                        if (nxt.mode != MODE_OFF)
                        begin
                            nxt.mode = MODE_OFF;
                            enter = 1'b1;
                        end
                    end
                end
                CMD_REC_START:
                begin
                    if (!nxt.locked && !nxt.shutdown_wait)
                    begin
                        if (nxt.mode != MODE_RECORDING)
                        begin
                            nxt.mode = MODE_RECORDING;
                            enter = 1'b1;
                        end
                        confirm = 1'b1;
                    end
                end
                CMD_REC_STOP:
                begin
                    if (!nxt.locked)
                    begin
                        if (nxt.mode != MODE_IDLE)
                        begin
                            nxt.mode = MODE_IDLE;
                            enter = 1'b1;
                        end
                        stop_cue = 1'b1;
                        if (nxt.shutdown_wait && nxt.stop_wait)
                        begin
                            nxt.stop_wait = 1'b0;
                            act = ACT_LONG;
                        end
                    end
                end
                CMD_ERROR:
                begin
                    nxt.error_code = arg;
                    err = 1'b1;
                    if (nxt.mode != MODE_ERROR)
                    begin
                        nxt.mode = MODE_ERROR;
                        enter = 1'b1;
                    end
                end
                CMD_SHORT, CMD_LONG:
                begin
                    if (!nxt.locked && !nxt.shutdown_wait)
                    begin
                        priority if (nxt.mode == MODE_IDLE)
                        begin
                            if (command == CMD_LONG)
                            begin
                                nxt.shutdown_wait = 1'b1;
                                act = ACT_LONG;
                            end
                            else
                            begin
                                act = ACT_SHORT;
                            end
                        end
                        else if (nxt.mode == MODE_RECORDING)
                        begin
                            if (command == CMD_LONG)
                            begin
                                nxt.shutdown_wait = 1'b1;
                                nxt.stop_wait = 1'b1;
                            end
                            act = ACT_SHORT;
                        end
                        else if ((nxt.mode == MODE_LOW_BAT || nxt.mode == MODE_ERROR)
                                 && command == CMD_LONG)
                        begin
                            nxt.shutdown_wait = 1'b1;
                            act = ACT_LONG;
                        end
                        else
                        begin
                            act = ACT_NONE;
                        end
                    end
                end
                default:
                begin
                    act = ACT_NONE;
                end
            endcase
        end

        res.action = act;
        res.mode = nxt.mode;
        res.error_code = nxt.error_code;
        res.battery_code = nxt.battery_code;
        res.locked = nxt.locked;
        res.shutdown_wait = nxt.shutdown_wait;
        res.cue_state_enter = enter;
        res.cue_error = err;
        res.cue_confirm = confirm;
        res.cue_stop = stop_cue;
    end

endmodule

`default_nettype wire

/* hw/rtl/recorder_power_record_controller_top.sv */
// Top level of the recorder power and record controller with its register port.
//
// Each accepted event word is decoded in the same cycle it is accepted: the
// controller state updates at that edge and the result word is registered
// then as well; a skid register holds one more result while the output is
// stalled. The rate of one word per cycle while the skid register is empty is
// set by the single decode stage between the state registers and the result
// register. The boot timeout register is at byte address 0 of the register port.
`default_nettype none

module recorder_power_record_controller_top
    import rprc_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,

    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [ADDR_W-1:0]  paddr,
    input  wire logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]       prdata,
    output logic                    pready,

    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [CMD_W-1:0]   command,
    input  wire logic [CODE_W-1:0]  arg,
    input  wire logic [TIME_W-1:0]  now_ms,

    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [1:0]              action,
    output logic [2:0]              ctrl_state_out,
    output logic [CODE_W-1:0]       error_out,
    output logic [CODE_W-1:0]       battery_out,
    output logic                    lockout_out,
    output logic                    shutdown_out,
    output logic                    cue_state_enter,
    output logic                    cue_error,
    output logic                    cue_confirm,
    output logic                    cue_stop
);

    logic [TIME_W-1:0] boot_timeout_reg;
    ctrl_state_t       state_reg;
    ctrl_state_t       state_next;
    result_t           res_next;
    result_t           out_reg;
    result_t           skid_reg;
    logic              out_valid_reg;
    logic              skid_valid_reg;
    logic              in_fire;
    logic              out_free;
    logic              cfg_write;

    assign pready = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata = (paddr[2] == REG_BOOT_TIMEOUT) ? boot_timeout_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            boot_timeout_reg <= BOOT_TIMEOUT_RESET;
        end
        else if (cfg_write && paddr[2] == REG_BOOT_TIMEOUT)
        begin
            boot_timeout_reg <= pwdata;
        end
    end

    assign in_ready = !skid_valid_reg;
    assign in_fire = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    rprc_step u_step (
        .cur             (state_reg),
        .command         (command),
        .arg             (arg),
        .now_ms          (now_ms),
        .boot_timeout_ms (boot_timeout_reg),
        .nxt             (state_next),
        .res             (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.mode <= MODE_BOOTING;
            state_reg.battery_code <= BAT_UNSET;
            state_reg.locked <= 1'b0;
            state_reg.error_code <= ERR_CLEAR;
            state_reg.boot_deadline <= BOOT_TIMEOUT_RESET;
            state_reg.shutdown_wait <= 1'b0;
            state_reg.stop_wait <= 1'b0;
        end
        else if (in_fire)
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= in_fire;
            end
        end
        else if (in_fire)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_reg <= skid_reg;
            end
            else if (in_fire)
            begin
                out_reg <= res_next;
            end
        end
        else if (in_fire)
        begin
            skid_reg <= res_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign action = out_reg.action;
    assign ctrl_state_out = out_reg.mode;
    assign error_out = out_reg.error_code;
    assign battery_out = out_reg.battery_code;
    assign lockout_out = out_reg.locked;
    assign shutdown_out = out_reg.shutdown_wait;
    assign cue_state_enter = out_reg.cue_state_enter;
    assign cue_error = out_reg.cue_error;
    assign cue_confirm = out_reg.cue_confirm;
    assign cue_stop = out_reg.cue_stop;

endmodule

`default_nettype wire

/* hw/rtl/rprc_checker.sv */
// Port-level assertions for the controller and the bind that attaches them.
`default_nettype none

module rprc_checker
    import rprc_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               psel,
    input wire logic               penable,
    input wire logic               pwrite,
    input wire logic [ADDR_W-1:0]  paddr,
    input wire logic [DATA_W-1:0]  pwdata,
    input wire logic [DATA_W-1:0]  prdata,
    input wire logic               pready,
    input wire logic               in_valid,
    input wire logic               in_ready,
    input wire logic [CMD_W-1:0]   command,
    input wire logic [CODE_W-1:0]  arg,
    input wire logic [TIME_W-1:0]  now_ms,
    input wire logic               out_valid,
    input wire logic               out_ready,
    input wire logic [1:0]         action,
    input wire logic [2:0]         ctrl_state_out,
    input wire logic [CODE_W-1:0]  error_out,
    input wire logic [CODE_W-1:0]  battery_out,
    input wire logic               lockout_out,
    input wire logic               shutdown_out,
    input wire logic               cue_state_enter,
    input wire logic               cue_error,
    input wire logic               cue_confirm,
    input wire logic               cue_stop
);

    // A stalled result word holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(action)
            && $stable(ctrl_state_out) && $stable(error_out) && $stable(cue_error))
        else $error("stalled result word changed");

    // A start word taken into a free output shows up next cycle as a long press into booting.
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && command == CMD_START && (!out_valid || out_ready)
        |=> out_valid && action == ACT_LONG && ctrl_state_out == MODE_BOOTING
            && cue_state_enter && !lockout_out && error_out == ERR_CLEAR)
        else $error("start word did not produce a long press into booting");

    a_confirm_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && cue_confirm |-> ctrl_state_out == MODE_IDLE
            || ctrl_state_out == MODE_RECORDING)
        else $error("confirmation cue outside idle or recording");

    a_stop_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && cue_stop |-> ctrl_state_out == MODE_IDLE)
        else $error("stop cue outside idle");

    // No press reaches the recorder while the battery lockout is active.
    a_lock_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && lockout_out |-> action == ACT_NONE)
        else $error("press issued during lockout");

endmodule

bind recorder_power_record_controller_top rprc_checker u_rprc_checker (.*);

`default_nettype wire

/* tb/recorder_power_record_controller_checker.sv */
// Checker that predicts each result word of the recorder controller and compares it.
module recorder_power_record_controller_checker
    import rprc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [DATA_W-1:0]  pwdata,
    input  logic [DATA_W-1:0]  prdata,
    input  logic               pready,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic [CMD_W-1:0]   command,
    input  logic [CODE_W-1:0]  arg,
    input  logic [TIME_W-1:0]  now_ms,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic [1:0]         action,
    input  logic [2:0]         ctrl_state_out,
    input  logic [CODE_W-1:0]  error_out,
    input  logic [CODE_W-1:0]  battery_out,
    input  logic               lockout_out,
    input  logic               shutdown_out,
    input  logic               cue_state_enter,
    input  logic               cue_error,
    input  logic               cue_confirm,
    input  logic               cue_stop,
    output int                 failures,
    output int                 pending
);
    timeunit 1ns;
    timeprecision 1ps;

    mode_t              mode_now;
    logic [CODE_W-1:0]  battery_now;
    logic [CODE_W-1:0]  error_now;
    logic               locked_now;
    logic               shutdown_now;
    logic               stop_now;
    logic [TIME_W-1:0]  deadline;
    logic [TIME_W-1:0]  boot_timeout;
    logic               entered;
    result_t            expected_q[$];

    function automatic void enter_mode(mode_t next);
        if (next != mode_now)
        begin
            mode_now = next;
            entered = 1'b1;
        end
    endfunction

    function automatic bit count_failure();
        failures++;
        return failures <= 10;
    endfunction

    function automatic result_t step_controller(logic [CMD_W-1:0] cmd,
                                                logic [CODE_W-1:0] code,
                                                logic [TIME_W-1:0] stamp);
        result_t            outcome;
        logic [TIME_W-1:0]  elapsed;
        logic               held;
        outcome = '0;
        entered = 1'b0;
        if (cmd == CMD_START)
        begin
            mode_now = MODE_BOOTING;
            battery_now = BAT_UNSET;
            locked_now = 1'b0;
            error_now = ERR_CLEAR;
            shutdown_now = 1'b0;
            stop_now = 1'b0;
            deadline = stamp + boot_timeout;
            entered = 1'b1;
            outcome.action = ACT_LONG;
        end
        else
        begin
            // The deadline has passed when the wrapped difference is not negative.
            elapsed = stamp - deadline;
            if (mode_now == MODE_BOOTING && !elapsed[TIME_W-1] && !locked_now)
            begin
                error_now = ERR_BOOT_TIMEOUT;
                outcome.cue_error = 1'b1;
                enter_mode(MODE_ERROR);
            end
            case (cmd)
                CMD_BATTERY:
                begin
                    battery_now = code;
                    if (!locked_now && battery_now == BAT_CRIT)
                    begin
                        error_now = ERR_BAT_CRIT;
                        enter_mode(MODE_LOW_BAT);
                    end
                end
                CMD_LOCK_ENTER:
                begin
                    locked_now = 1'b1;
                    error_now = ERR_LOCK;
                    enter_mode(MODE_LOCKOUT);
                end
                CMD_LOCK_EXIT:
                begin
                    locked_now = 1'b0;
                    error_now = ERR_CLEAR;
                    enter_mode(MODE_OFF);
                end
                CMD_READY:
                begin
                    if (mode_now == MODE_BOOTING && !locked_now)
                    begin
                        error_now = ERR_CLEAR;
                        enter_mode(MODE_IDLE);
                        outcome.cue_confirm = 1'b1;
                    end
                end
                CMD_OFF:
                begin
                    if (!locked_now)
                    begin
                        shutdown_now = 1'b0;
                        stop_now = 1'b0;
                        error_now = ERR_CLEAR;
                        enter_mode(MODE_OFF);
                    end
                end
                CMD_REC_START:
                begin
                    if (!locked_now && !shutdown_now)
                    begin
                        enter_mode(MODE_RECORDING);
                        outcome.cue_confirm = 1'b1;
                    end
                end
                CMD_REC_STOP:
                begin
                    if (!locked_now)
                    begin
                        enter_mode(MODE_IDLE);
                        outcome.cue_stop = 1'b1;
                        if (shutdown_now && stop_now)
                        begin
                            stop_now = 1'b0;
                            outcome.action = ACT_LONG;
                        end
                    end
                end
                CMD_ERROR:
                begin
                    error_now = code;
                    outcome.cue_error = 1'b1;
                    enter_mode(MODE_ERROR);
                end
                CMD_SHORT, CMD_LONG:
                begin
                    held = (cmd == CMD_LONG);
                    if (!locked_now && !shutdown_now)
                    begin
                        if (mode_now == MODE_IDLE)
                        begin
                            shutdown_now = held;
                            outcome.action = held ? ACT_LONG : ACT_SHORT;
                        end
                        else if (mode_now == MODE_RECORDING)
                        begin
                            // A long press while recording stops first and powers down later.
                            shutdown_now = held;
                            stop_now = held;
                            outcome.action = ACT_SHORT;
                        end
                        else if ((mode_now == MODE_LOW_BAT || mode_now == MODE_ERROR) && held)
                        begin
                            shutdown_now = 1'b1;
                            outcome.action = ACT_LONG;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
        outcome.mode = mode_now;
        outcome.error_code = error_now;
        outcome.battery_code = battery_now;
        outcome.locked = locked_now;
        outcome.shutdown_wait = shutdown_now;
        outcome.cue_state_enter = entered;
        return outcome;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t seen;
        result_t want;
        if (!rst_n)
        begin
            mode_now = MODE_BOOTING;
            battery_now = BAT_UNSET;
            error_now = ERR_CLEAR;
            locked_now = 1'b0;
            shutdown_now = 1'b0;
            stop_now = 1'b0;
            deadline = BOOT_TIMEOUT_RESET;
            boot_timeout = BOOT_TIMEOUT_RESET;
            expected_q.delete();
            failures = 0;
            pending = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                seen = {action, ctrl_state_out, error_out, battery_out, lockout_out,
                        shutdown_out, cue_state_enter, cue_error, cue_confirm, cue_stop};
                if (expected_q.size() == 0)
                begin
                    if (count_failure())
                        $display("%0t: result word with nothing expected", $realtime);
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (seen !== want && count_failure())
                        $display("%0t: result mismatch, expected act %0d st %0d err %0h ",
                                 $realtime, want.action, want.mode, want.error_code,
                                 "bat %0h lock %b shut %b cues %b%b%b%b, ",
                                 want.battery_code, want.locked, want.shutdown_wait,
                                 want.cue_state_enter, want.cue_error, want.cue_confirm,
                                 want.cue_stop,
                                 "got act %0d st %0d err %0h bat %0h lock %b shut %b ",
                                 seen.action, seen.mode, seen.error_code,
                                 seen.battery_code, seen.locked, seen.shutdown_wait,
                                 "cues %b%b%b%b",
                                 seen.cue_state_enter, seen.cue_error, seen.cue_confirm,
                                 seen.cue_stop);
                end
            end
            if (in_valid && in_ready)
                expected_q.push_back(step_controller(command, arg, now_ms));
            if (psel && penable && pready && paddr[1:0] == 2'b00
                && paddr[ADDR_W-1:2] == REG_BOOT_TIMEOUT)
            begin
                if (pwrite)
                    boot_timeout = pwdata;
                else if (prdata !== boot_timeout && count_failure())
                    $display("%0t: register read mismatch, expected %h, got %h",
                             $realtime, boot_timeout, prdata);
            end
            pending = expected_q.size();
        end
    end

endmodule

/* tb/recorder_power_record_controller_top_test.sv */
// Top of the recorder controller testbench: clock, reset, stimulus and verdict.
module recorder_power_record_controller_top_test;
    import rprc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CMD_W-1:0]  CMD_SPARE_LO = 4'd12;
    localparam logic [CMD_W-1:0]  CMD_SPARE_HI = 4'd15;
    localparam logic [ADDR_W-1:0] TIMEOUT_ADDR = {REG_BOOT_TIMEOUT, 2'b00};
    localparam logic [ADDR_W-1:0] SPARE_ADDR = {~REG_BOOT_TIMEOUT, 2'b00};

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [ADDR_W-1:0]  paddr = '0;
    logic [DATA_W-1:0]  pwdata = '0;
    logic [DATA_W-1:0]  prdata;
    logic               pready;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [CMD_W-1:0]   command = '0;
    logic [CODE_W-1:0]  arg = '0;
    logic [TIME_W-1:0]  now_ms = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [1:0]         action;
    logic [2:0]         ctrl_state_out;
    logic [CODE_W-1:0]  error_out;
    logic [CODE_W-1:0]  battery_out;
    logic               lockout_out;
    logic               shutdown_out;
    logic               cue_state_enter;
    logic               cue_error;
    logic               cue_confirm;
    logic               cue_stop;
    int                 failures;
    int                 pending;
    bit                 quiet = 1'b0;

    recorder_power_record_controller_top uut (.*);
    recorder_power_record_controller_checker checker_i (.*);

    initial
    begin
        forever #10 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("recorder_power_record_controller_top_test: done, errors");
        $finish;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 50)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [CODE_W-1:0] code,
                             input logic [TIME_W-1:0] stamp);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        in_valid <= 1'b1;
        command <= cmd;
        arg <= code;
        now_ms <= stamp;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic apb_access(input logic wr, input logic [ADDR_W-1:0] addr,
                              input logic [DATA_W-1:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    initial
    begin
        int stall;
        stall = 0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                stall--;
            end
            else
            begin
                out_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    stall = gap_len();
            end
        end
    end

    initial
    begin
        logic [TIME_W-1:0]  stamp;
        logic [DATA_W-1:0]  limits [6];
        logic [CMD_W-1:0]   cmd;
        logic [CODE_W-1:0]  code;
        int                 r;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(CMD_TICK, 8'h00, 32'd0);
        send_word(CMD_BATTERY, 8'hFF, 32'd100);
        send_word(CMD_BATTERY, BAT_CRIT, 32'd200);
        send_word(CMD_SHORT, 8'h00, 32'd300);
        send_word(CMD_LONG, 8'h00, 32'd400);
        send_word(CMD_OFF, 8'h00, 32'd500);
        send_word(CMD_START, 8'hFF, 32'hFFFF_FF00);
        send_word(CMD_READY, 8'h00, 32'hFFFF_FFF0);
        send_word(CMD_SHORT, 8'h00, 32'h0000_0010);
        send_word(CMD_REC_START, 8'h00, 32'h0000_0020);
        send_word(CMD_LONG, 8'h00, 32'h0000_0030);
        send_word(CMD_REC_START, 8'h00, 32'h0000_0040);
        send_word(CMD_REC_STOP, 8'h00, 32'h0000_0050);
        send_word(CMD_LOCK_ENTER, 8'h00, 32'h0000_0060);
        send_word(CMD_SHORT, 8'h00, 32'h0000_0070);
        send_word(CMD_BATTERY, BAT_CRIT, 32'h0000_0080);
        send_word(CMD_READY, 8'h00, 32'h0000_0090);
        send_word(CMD_LOCK_EXIT, 8'h00, 32'h0000_00A0);
        send_word(CMD_ERROR, 8'hFF, 32'h0000_00B0);
        send_word(CMD_LONG, 8'h00, 32'h0000_00C0);
        send_word(CMD_SPARE_LO, 8'h55, 32'h0000_00D0);
        send_word(CMD_SPARE_HI, 8'hAA, 32'h0000_00E0);
        send_word(CMD_START, 8'h00, 32'd5);
        send_word(CMD_TICK, 8'h00, 32'd10004);
        send_word(CMD_TICK, 8'h00, 32'd10005);
        send_word(CMD_START, 8'h00, 32'h7FFF_0000);
        send_word(CMD_LOCK_ENTER, 8'h00, 32'h7FFF_0000);
        send_word(CMD_TICK, 8'h00, 32'h7FFF_9000);
        send_word(CMD_LOCK_EXIT, 8'h00, 32'h7FFF_9001);

        limits[0] = 32'd0;
        limits[1] = 32'hFFFF_FFFF;
        limits[2] = 32'd1;
        limits[3] = $urandom_range(50, 3000);
        limits[4] = $urandom();
        limits[5] = BOOT_TIMEOUT_RESET;

        for (int p = 0; p < 6; p++)
        begin
            drain_results();
            apb_access(1'b1, TIMEOUT_ADDR, limits[p]);
            if (p == 3)
                apb_access(1'b1, SPARE_ADDR, $urandom());
            apb_access(1'b0, TIMEOUT_ADDR, '0);
            stamp = $urandom();
            for (int k = 0; k < 170; k++)
            begin
                quiet = (k % 100) >= 70;
                r = $urandom_range(0, 99);
                if (r < 85)
                    stamp = stamp + $urandom_range(0, 60);
                else if (r < 97)
                    stamp = stamp + $urandom_range(0, 20000);
                else
                    stamp = $urandom();
                code = CODE_W'($urandom_range(0, 255));
                r = $urandom_range(0, 99);
                if (r < 8)
                    cmd = CMD_START;
                else if (r < 20)
                    cmd = CMD_READY;
                else if (r < 32)
                    cmd = CMD_REC_START;
                else if (r < 42)
                    cmd = CMD_REC_STOP;
                else if (r < 52)
                    cmd = CMD_SHORT;
                else if (r < 62)
                    cmd = CMD_LONG;
                else if (r < 68)
                    cmd = CMD_OFF;
                else if (r < 78)
                    cmd = CMD_TICK;
                else if (r < 86)
                begin
                    cmd = CMD_BATTERY;
                    if ($urandom_range(0, 9) < 4)
                        code = BAT_CRIT;
                end
                else if (r < 89)
                    cmd = CMD_LOCK_ENTER;
                else if (r < 93)
                    cmd = CMD_LOCK_EXIT;
                else if (r < 97)
                    cmd = CMD_ERROR;
                else
                    cmd = CMD_W'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
                send_word(cmd, code, stamp);
            end
            quiet = 1'b0;
        end

        drain_results();
        repeat (4) @(posedge clk);
        if (failures == 0 && pending == 0)
            $display("recorder_power_record_controller_top_test: done, clean");
        else
            $display("recorder_power_record_controller_top_test: done, errors");
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/rprc_pkg.sv
hw/rtl/rprc_step.sv
hw/rtl/recorder_power_record_controller_top.sv
hw/rtl/rprc_checker.sv
tb/recorder_power_record_controller_checker.sv
tb/recorder_power_record_controller_top_test.sv
